/* sv/assert_macros.svh */
// Assertion helper macros for the RTL; included by second_schedule_trigger_top.
// Expects a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define SSCHED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define SSCHED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/ssched_pkg.sv */
// Types and constants for the second-based schedule trigger.
// No dependencies; used by ssched_div and second_schedule_trigger_top.
`default_nettype none

package ssched_pkg;

  // Field widths
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned TIME_W = 17;  // seconds of day
  localparam int unsigned SPD_W  = 17;  // sends per day

  // Clamp limits and time constants
  localparam logic [HOUR_W-1:0] HOUR_MAX       = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_MAX        = 6'd59;
  localparam logic [SEC_W-1:0]  SEC_MAX        = 6'd59;
  localparam logic [TIME_W-1:0] SECS_PER_HOUR  = 17'd3600;
  localparam logic [TIME_W-1:0] SECS_PER_MIN   = 17'd60;
  localparam logic [SPD_W-1:0]  SPD_RESET      = 17'd24;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

/* sv/ssched_div.sv */
// Restoring serial divider: constant dividend over a run-time divisor, one bit a cycle.
// Uses ssched_pkg for the divisor width.
`default_nettype none

module ssched_div #(
  parameter int unsigned DIVIDEND_VALUE = 86400
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [ssched_pkg::SPD_W-1:0]      divisor_i,
  output logic                                   done_o,
  output logic [$clog2(DIVIDEND_VALUE+1)-1:0]    quot_o
);

  localparam int unsigned QW = $clog2(DIVIDEND_VALUE + 1);
  localparam int unsigned CW = $clog2(QW + 1);
  localparam int unsigned DW = ssched_pkg::SPD_W;
  localparam logic [QW-1:0] DVD   = QW'(DIVIDEND_VALUE);
  localparam logic [CW-1:0] STEPS = CW'(QW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [QW-1:0] dvd_q, dvd_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [DW-1:0] rem_q, rem_d;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit, try a subtract
  always_comb begin
    trial = {rem_q, dvd_q[QW-1]};
    diff  = trial - {1'b0, divisor_i};
    fits  = (trial >= {1'b0, divisor_i});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEPS;
      dvd_d  = DVD;
      quot_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d  = fits ? diff[DW-1:0] : trial[DW-1:0];
      quot_d = {quot_q[QW-2:0], fits};
      dvd_d  = {dvd_q[QW-2:0], 1'b0};
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* sv/second_schedule_trigger_top.sv */
// Each accepted item passes through IDLE, DIV and OUT in turn; the result is shown in OUT
// until out_stall_i is low. The serial interval divider (one quotient bit per cycle) sets the
// pace. Input stalls while an item is busy, so a new item is taken only after the last has left OUT.
// Reset (async, active low): sends_per_day = 24, next due second, hold flag and previous
// hour cleared, no result pending.
`default_nettype none

module second_schedule_trigger_top #(
  parameter int unsigned DAY_SECONDS = 86400
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [ssched_pkg::SPD_W-1:0]    cfg_sends_per_day_i,
  // input items
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [ssched_pkg::HOUR_W-1:0]   hour_i,
  input  wire logic [ssched_pkg::MIN_W-1:0]    minute_i,
  input  wire logic [ssched_pkg::SEC_W-1:0]    second_i,
  // results
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 fire_o
);

  localparam int unsigned QW = $clog2(DAY_SECONDS + 1);
  localparam int unsigned TW = ssched_pkg::TIME_W;
  localparam int unsigned HW = ssched_pkg::HOUR_W;
  localparam logic [TW:0] DAY_LEN = (TW + 1)'(DAY_SECONDS);

  ssched_pkg::state_e state_q, state_d;

  logic [ssched_pkg::SPD_W-1:0] spd_q;
  logic [TW-1:0]                next_due_q, next_due_d;
  logic                         hold_q, hold_d;
  logic [HW-1:0]                prev_hour_q, prev_hour_d;
  logic                         fire_q, fire_d;
  logic [TW-1:0]                now_q;
  logic [HW-1:0]                hour_q;

  logic                         in_acc;
  logic                         div_start;
  logic                         div_done;
  logic [QW-1:0]                interval;
  logic [ssched_pkg::SPD_W-1:0] divisor;

  logic [HW-1:0]                h_c;
  logic [ssched_pkg::MIN_W-1:0] m_c;
  logic [ssched_pkg::SEC_W-1:0] s_c;
  logic [TW-1:0]                now_c;
  logic                         hold_eff;
  logic [TW:0]                  due;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign div_start   = in_acc;
  assign divisor     = (spd_q == '0) ? {{(ssched_pkg::SPD_W-1){1'b0}}, 1'b1} : spd_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_q <= ssched_pkg::SPD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      spd_q <= cfg_sends_per_day_i;
    end
  end

  // Clamp fields and form seconds since midnight
  always_comb begin
    h_c   = (hour_i > ssched_pkg::HOUR_MAX) ? ssched_pkg::HOUR_MAX : hour_i;
    m_c   = (minute_i > ssched_pkg::MIN_MAX) ? ssched_pkg::MIN_MAX : minute_i;
    s_c   = (second_i > ssched_pkg::SEC_MAX) ? ssched_pkg::SEC_MAX : second_i;
    now_c = TW'(h_c) * ssched_pkg::SECS_PER_HOUR
          + TW'(m_c) * ssched_pkg::SECS_PER_MIN
          + TW'(s_c);
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q  <= now_c;
      hour_q <= h_c;
    end
  end

  // Interval = day length / sends per day
  ssched_div #(
    .DIVIDEND_VALUE(DAY_SECONDS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .divisor_i(divisor),
    .done_o   (div_done),
    .quot_o   (interval)
  );

  // Trigger decision once the interval is known
  always_comb begin
    hold_eff = hold_q && !(hour_q < prev_hour_q);
    due      = {1'b0, now_q} + (TW + 1)'(interval);
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssched_pkg::ST_IDLE;
      next_due_q  <= '0;
      hold_q      <= 1'b0;
      prev_hour_q <= '0;
      fire_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_due_q  <= next_due_d;
      hold_q      <= hold_d;
      prev_hour_q <= prev_hour_d;
      fire_q      <= fire_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    next_due_d  = next_due_q;
    hold_d      = hold_q;
    prev_hour_d = prev_hour_q;
    fire_d      = fire_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ssched_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ssched_pkg::ST_DIV;
        end
      end
      ssched_pkg::ST_DIV: begin
        if (div_done) begin
          state_d     = ssched_pkg::ST_OUT;
          prev_hour_d = hour_q;
          hold_d      = hold_eff;
          fire_d      = 1'b0;
          if ((now_q >= next_due_q) && !hold_eff) begin
            fire_d = 1'b1;
            if (due >= DAY_LEN) begin
              hold_d     = 1'b1;
              next_due_d = TW'(due - DAY_LEN);
            end else begin
              next_due_d = due[TW-1:0];
            end
          end
        end
      end
      ssched_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = ssched_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssched_pkg::ST_IDLE;
      end
    endcase
  end

  assign fire_o = fire_q;

`include "assert_macros.svh"

  `SSCHED_ASSERT(a_acc_starts_div, in_acc |=> (state_q == ssched_pkg::ST_DIV), "accept did not start division")
  `SSCHED_ASSERT(a_done_in_div, div_done |-> (state_q == ssched_pkg::ST_DIV), "divider done outside DIV")
  `SSCHED_ASSERT(a_out_after_done, $rose(out_valid_o) |-> $past(div_done), "result without divider done")
  `SSCHED_ASSERT_ALWAYS(a_out_blocks_in, out_valid_o |-> in_stall_o, "input open while result pending")

endmodule

`default_nettype wire
